// ===== sv/rspe_pkg.sv =====
// ----------------------------------------------------------------------------
// rspe_pkg
// Field, code and queue-entry definitions shared by the parity encoder.
// ----------------------------------------------------------------------------
`default_nettype none

package rspe_pkg;

  localparam int SymBits   = 8;
  localparam int CorrCap   = 8;
  localparam int ParLen    = 2 * CorrCap;
  localparam int FieldSize = (1 << SymBits) - 1;
  localparam int DataLen   = FieldSize - ParLen;
  localparam int IdxW      = $clog2(ParLen);

  // no data symbols fit: every block is a length error
  localparam bit EmptyCode = (DataLen < 1);
  localparam logic [7:0] DataLenCnt = EmptyCode ? 8'd0 : 8'(DataLen);

  typedef logic [SymBits-1:0] sym_t;
  typedef logic [SymBits:0]   poly_t;

  function automatic poly_t prim_poly();
    case (SymBits)
      4:       return poly_t'(9'h013);
      5:       return poly_t'(9'h025);
      6:       return poly_t'(9'h043);
      7:       return poly_t'(9'h089);
      default: return poly_t'(9'h11D);
    endcase
  endfunction

  localparam poly_t PrimPoly = prim_poly();

  // shift-and-add multiply in gf(2^m); with one constant operand it folds to xors
  function automatic sym_t gf_mul(sym_t a, sym_t b);
    poly_t aa;
    sym_t  bb;
    sym_t  acc;
    acc = '0;
    aa  = {1'b0, a};
    bb  = b;
    for (int i = 0; i < SymBits; i++) begin
      if (bb[0]) begin
        acc = acc ^ aa[SymBits-1:0];
      end
      bb = bb >> 1;
      aa = aa << 1;
      if (aa[SymBits]) begin
        aa = aa ^ PrimPoly;
      end
    end
    return acc;
  endfunction

  // coefficient idx of the generator with roots alpha^1 .. alpha^2t
  function automatic sym_t gen_coef(int idx);
    sym_t g [ParLen+1];
    sym_t root;
    for (int k = 0; k <= ParLen; k++) begin
      g[k] = '0;
    end
    g[0] = sym_t'(1);
    root = sym_t'(1);
    for (int i = 1; i <= ParLen; i++) begin
      root = gf_mul(root, sym_t'(2));
      g[i] = '0;
      for (int j = i; j >= 1; j--) begin
        g[j] = g[j-1] ^ gf_mul(g[j], root);
      end
      g[0] = gf_mul(g[0], root);
    end
    return g[idx];
  endfunction

  typedef struct packed {
    logic                     err;
    sym_t [ParLen-1:0]        par;
  } job_t;

  typedef struct packed {
    logic full;
    logic avail;
  } qstat_t;

endpackage

`default_nettype wire

// ===== sv/reed_solomon_parity_encoder.sv =====
// ----------------------------------------------------------------------------
// reed_solomon_parity_encoder
// Systematic RS parity generator, RS(255,239) over GF(2^8) by default.
// ----------------------------------------------------------------------------
// Data symbols enter one per clock while in_stall_o is low, highest degree
// first, and go straight into the 2t-symbol division register. The request
// marked last closes the block: its 2t parity symbols (or one length-error
// result when the block did not hold exactly k symbols) move into a two-entry
// queue and leave one per clock while out_stall_i is low, index 0 first; each
// block passes from its queue entry into the output register. The input takes
// one symbol per clock and stalls only while the queue holds two finished
// blocks behind the one being sent, so a new block can enter while the last
// one is still being sent.
`default_nettype none

module reed_solomon_parity_encoder import rspe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  output logic            in_stall_o,
  input  wire logic [7:0] data_symbol_i,
  input  wire logic       last_symbol_i,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      parity_symbol_o,
  output logic            end_of_parity_o,
  output logic            length_error_o
);

  logic   push, pop;
  job_t   job_in, job_out;
  qstat_t qstat;

  assign in_stall_o = qstat.full;

  rspe_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .in_valid_i    (in_valid_i),
    .data_symbol_i (data_symbol_i),
    .last_symbol_i (last_symbol_i),
    .stall_i       (qstat.full),
    .push_o        (push),
    .job_o         (job_in)
  );

  rspe_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (job_in),
    .pop_i  (pop),
    .job_o  (job_out),
    .stat_o (qstat)
  );

  rspe_back u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .job_i           (job_out),
    .stat_i          (qstat),
    .pop_o           (pop),
    .out_valid_o     (out_valid_o),
    .out_stall_i     (out_stall_i),
    .parity_symbol_o (parity_symbol_o),
    .end_of_parity_o (end_of_parity_o),
    .length_error_o  (length_error_o)
  );

endmodule

`default_nettype wire

// ===== sv/rspe_front.sv =====
// ----------------------------------------------------------------------------
// rspe_front
// Takes data symbols, runs the division register and checks block length.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_front import rspe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       in_valid_i,
  input  wire logic [7:0] data_symbol_i,
  input  wire logic       last_symbol_i,
  input  wire logic       stall_i,
  output logic            push_o,
  output job_t            job_o
);

  sym_t [ParLen-1:0] rem_q, rem_d, upd;
  logic [7:0]        cnt_q, cnt_d, cnt_new;
  logic              ovf_q, ovf_d, ovf_new;
  logic              accept, cnt_sat, bad;
  sym_t              sym, fb;

  assign accept = in_valid_i & ~stall_i;
  assign sym    = data_symbol_i[SymBits-1:0];
  assign fb     = sym ^ rem_q[ParLen-1];

  for (genvar j = 0; j < ParLen; j++) begin : g_tap
    localparam sym_t Coef = gen_coef(j);
    if (j == 0) begin : g_first
      assign upd[j] = gf_mul(Coef, fb);
    end else begin : g_rest
      assign upd[j] = rem_q[j-1] ^ gf_mul(Coef, fb);
    end
  end

  assign cnt_sat = (cnt_q == 8'hFF);
  assign cnt_new = cnt_sat ? cnt_q : cnt_q + 8'd1;
  assign ovf_new = ovf_q | cnt_sat;
  assign bad     = ovf_new | EmptyCode | (cnt_new != DataLenCnt);

  assign push_o    = accept & last_symbol_i;
  assign job_o.err = bad;
  assign job_o.par = bad ? '0 : upd;

  always_comb begin
    rem_d = rem_q;
    cnt_d = cnt_q;
    ovf_d = ovf_q;
    if (accept) begin
      if (last_symbol_i) begin
        rem_d = '0;
        cnt_d = '0;
        ovf_d = 1'b0;
      end else begin
        rem_d = upd;
        cnt_d = cnt_new;
        ovf_d = ovf_new;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rem_q <= '0;
      cnt_q <= '0;
      ovf_q <= 1'b0;
    end else begin
      rem_q <= rem_d;
      cnt_q <= cnt_d;
      ovf_q <= ovf_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rspe_queue.sv =====
// ----------------------------------------------------------------------------
// rspe_queue
// Two-entry queue of finished blocks between front and back.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_queue import rspe_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  job_t      job_i,
  input  wire logic pop_i,
  output job_t      job_o,
  output qstat_t    stat_o
);

  job_t       mem_q [2];
  logic       wr_q, wr_d, rd_q, rd_d;
  logic [1:0] cnt_q, cnt_d;

  assign job_o        = mem_q[rd_q];
  assign stat_o.full  = (cnt_q == 2'd2);
  assign stat_o.avail = (cnt_q != 2'd0);

  always_comb begin
    wr_d  = push_i ? ~wr_q : wr_q;
    rd_d  = pop_i ? ~rd_q : rd_q;
    cnt_d = cnt_q + {1'b0, push_i} - {1'b0, pop_i};
  end

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= 1'b0;
      rd_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rspe_back.sv =====
// ----------------------------------------------------------------------------
// rspe_back
// Sends out the parity symbols of one block, or its error result.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_back import rspe_pkg::*; (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  job_t            job_i,
  input  qstat_t          stat_i,
  output logic            pop_o,
  output logic            out_valid_o,
  input  wire logic       out_stall_i,
  output logic [7:0]      parity_symbol_o,
  output logic            end_of_parity_o,
  output logic            length_error_o
);

  logic              busy_q, busy_d, err_q, err_d;
  sym_t [ParLen-1:0] par_q, par_d;
  logic [IdxW-1:0]   idx_q, idx_d;
  logic              last, advance;

  assign last    = err_q | (idx_q == IdxW'(ParLen - 1));
  assign advance = busy_q & ~out_stall_i;
  // next block loads in the same cycle the previous one finishes
  assign pop_o   = stat_i.avail & (~busy_q | (advance & last));

  assign out_valid_o     = busy_q;
  assign parity_symbol_o = 8'(par_q[0]);
  assign end_of_parity_o = last;
  assign length_error_o  = err_q;

  always_comb begin
    busy_d = busy_q;
    err_d  = err_q;
    par_d  = par_q;
    idx_d  = idx_q;
    if (pop_o) begin
      busy_d = 1'b1;
      err_d  = job_i.err;
      par_d  = job_i.par;
      idx_d  = '0;
    end else if (advance) begin
      busy_d = ~last;
      par_d  = {sym_t'(0), par_q[ParLen-1:1]};
      idx_d  = idx_q + IdxW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    par_q <= par_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      err_q  <= 1'b0;
      idx_q  <= '0;
    end else begin
      busy_q <= busy_d;
      err_q  <= err_d;
      idx_q  <= idx_d;
    end
  end

endmodule

`default_nettype wire

// ===== sv/rspe_checker.sv =====
// ----------------------------------------------------------------------------
// rspe_checker
// Port-level checks on the parity encoder, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rspe_checker (
  input wire logic       clk_i,
  input wire logic       rst_ni,
  input wire logic       out_valid_o,
  input wire logic       out_stall_i,
  input wire logic [7:0] parity_symbol_o,
  input wire logic       end_of_parity_o,
  input wire logic       length_error_o
);

  // a stalled result holds
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(parity_symbol_o)
      && $stable(end_of_parity_o) && $stable(length_error_o))
    else $error("stalled result changed");

  // error result is a single zero symbol closing the block
  a_err: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && length_error_o |-> end_of_parity_o && parity_symbol_o == 8'd0)
    else $error("malformed length error result");

  // parity symbols of one block leave without gaps
  a_burst: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !end_of_parity_o |=> out_valid_o && !length_error_o)
    else $error("gap inside parity burst");

endmodule

bind reed_solomon_parity_encoder rspe_checker u_rspe_checker (
  .clk_i           (clk_i),
  .rst_ni          (rst_ni),
  .out_valid_o     (out_valid_o),
  .out_stall_i     (out_stall_i),
  .parity_symbol_o (parity_symbol_o),
  .end_of_parity_o (end_of_parity_o),
  .length_error_o  (length_error_o)
);

`default_nettype wire

// ===== verif/tb_reed_solomon_parity_encoder.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_reed_solomon_parity_encoder
// Feeds data symbol blocks into the rs parity encoder and checks every parity
// or length-error result against a directed table or a log/antilog based lfsr model kept here.
// Starts with a table of short blocks, then a full codeword and short blocks
// under random stalls on both sides, and ends with an overlong block at full rate.
// ----------------------------------------------------------------------------

module tb_reed_solomon_parity_encoder;
  import rspe_pkg::*;

  localparam int ItemsTarget = 430;
  localparam int LongLen     = 256;
  localparam int HoldCycles  = 40;
  localparam int StuckLimit  = 2000;
  localparam int TailCycles  = 20;
  localparam int MaxPrints   = 20;

  typedef enum int {BlkGood, BlkShort} blk_kind_e;

  typedef struct packed {
    logic [7:0] symbol;
    logic       eop;
    logic       err;
  } parity_item_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
    logic       typed;
    logic [7:0] exp_sym;
    logic       exp_eop;
    logic       exp_err;
    logic       hold;
  } stim_row_t;

  function automatic logic [8:0] field_poly_for(int m);
    case (m)
      4:       return 9'h013;
      5:       return 9'h025;
      6:       return 9'h043;
      7:       return 9'h089;
      default: return 9'h11D;
    endcase
  endfunction

  localparam logic [SymBits:0] FieldPoly = field_poly_for(SymBits);

  logic       clk_i = 1'b0;
  logic       rst_ni = 1'b0;
  logic       in_valid_i = 1'b0;
  logic       in_stall_o;
  logic [7:0] data_symbol_i = 8'h00;
  logic       last_symbol_i = 1'b0;
  logic       out_valid_o;
  logic       out_stall_i = 1'b0;
  logic [7:0] parity_symbol_o;
  logic       end_of_parity_o;
  logic       length_error_o;

  reed_solomon_parity_encoder dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .in_valid_i     (in_valid_i),
    .in_stall_o     (in_stall_o),
    .data_symbol_i  (data_symbol_i),
    .last_symbol_i  (last_symbol_i),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .parity_symbol_o(parity_symbol_o),
    .end_of_parity_o(end_of_parity_o),
    .length_error_o (length_error_o)
  );

  always #5 clk_i = ~clk_i;

  // field tables, generator taps and the division register of the model
  sym_t        alog [2*FieldSize];
  int unsigned glog [1<<SymBits];
  sym_t        gen_tap [ParLen+1];
  sym_t        lfsr_rem [ParLen];
  int          blk_len;
  bit          blk_ovf;

  parity_item_t parity_q [$];

  int fail_cnt       = 0;
  int results_seen   = 0;
  int parity_pushed  = 0;
  int items_sent     = 0;
  int n_full         = 0;
  int n_err          = 0;
  int n_ovf          = 0;
  int stuck_cycles   = 0;
  int in_stall_seen  = 0;
  bit calm           = 1'b0;
  bit hold_req       = 1'b0;
  int hold_left      = 0;
  int rcv_burst      = 0;
  int rcv_quiet      = 0;
  int send_quiet     = 0;

  function automatic sym_t gf_times(sym_t a, sym_t b);
    if (a == '0 || b == '0) begin
      return '0;
    end
    return alog[glog[a] + glog[b]];
  endfunction

  // one symbol through the division register; results go to parity_q when keep
  function automatic void predict_symbol(logic [7:0] d, logic l, bit keep);
    sym_t fb;
    fb = sym_t'(d) ^ lfsr_rem[ParLen-1];
    for (int j = ParLen - 1; j >= 1; j--) begin
      lfsr_rem[j] = lfsr_rem[j-1] ^ gf_times(gen_tap[j], fb);
    end
    lfsr_rem[0] = gf_times(gen_tap[0], fb);
    if (blk_len >= 255) begin
      blk_ovf = 1'b1;
    end else begin
      blk_len++;
    end
    if (!l) begin
      return;
    end
    if (blk_ovf || DataLen < 1 || blk_len != DataLen) begin
      n_err++;
      if (blk_ovf) begin
        n_ovf++;
      end
      if (keep) begin
        parity_q.push_back('{8'h00, 1'b1, 1'b1});
        parity_pushed++;
      end
    end else begin
      n_full++;
      for (int n = 0; n < ParLen; n++) begin
        if (keep) begin
          parity_q.push_back('{8'(lfsr_rem[n]), 1'(n == ParLen - 1), 1'b0});
          parity_pushed++;
        end
      end
    end
    for (int j = 0; j < ParLen; j++) begin
      lfsr_rem[j] = '0;
    end
    blk_len = 0;
    blk_ovf = 1'b0;
  endfunction

  task automatic report_mismatch(string what, logic [7:0] got, logic [7:0] want);
    fail_cnt++;
    if (fail_cnt <= MaxPrints) begin
      $display("[%0t] mismatch on result %0d, %s: got %0h, want %0h",
               $realtime, results_seen, what, got, want);
    end
  endtask

  task automatic check_parity(logic [7:0] s, logic e, logic er);
    parity_item_t want;
    if (parity_q.size() == 0) begin
      report_mismatch("result with nothing pending", s, 8'h00);
      results_seen++;
      return;
    end
    want = parity_q.pop_front();
    if (s !== want.symbol) begin
      report_mismatch("parity_symbol", s, want.symbol);
    end
    if (e !== want.eop) begin
      report_mismatch("end_of_parity", 8'(e), 8'(want.eop));
    end
    if (er !== want.err) begin
      report_mismatch("length_error", 8'(er), 8'(want.err));
    end
    results_seen++;
  endtask

  // receiver: checks accepted results and drives stall
  always @(posedge clk_i) begin
    if (out_valid_o === 1'b1 && out_stall_i === 1'b0) begin
      check_parity(parity_symbol_o, end_of_parity_o, length_error_o);
    end
    if (hold_req) begin
      hold_req = 1'b0;
      hold_left = HoldCycles;
    end
    if (hold_left > 0) begin
      hold_left--;
      out_stall_i <= 1'b1;
    end else if (calm || rcv_quiet > 0) begin
      if (rcv_quiet > 0) begin
        rcv_quiet--;
      end
      out_stall_i <= 1'b0;
    end else if (rcv_burst > 0) begin
      rcv_burst--;
      out_stall_i <= 1'b1;
    end else if ($urandom_range(0, 39) == 0) begin
      rcv_quiet = $urandom_range(20, 60);
      out_stall_i <= 1'b0;
    end else if ($urandom_range(0, 3) == 0) begin
      rcv_burst = $urandom_range(0, 3);
      out_stall_i <= 1'b1;
    end else begin
      out_stall_i <= 1'b0;
    end
  end

  always @(posedge clk_i) begin
    if (in_valid_i && in_stall_o === 1'b1) begin
      in_stall_seen <= in_stall_seen + 1;
    end
    if ((in_valid_i && in_stall_o === 1'b0) || (out_valid_o === 1'b1 && !out_stall_i)) begin
      stuck_cycles <= 0;
    end else begin
      stuck_cycles <= stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    while (stuck_cycles < StuckLimit) begin
      @(posedge clk_i);
    end
    $display("timeout: no request moved for %0d cycles", StuckLimit);
    $display("** reed_solomon_parity_encoder: FAILED **");
    $finish;
  end

  // offer one symbol and return at the edge that takes it
  task automatic send_symbol(logic [7:0] d, logic l);
    if (!calm) begin
      if (send_quiet > 0) begin
        send_quiet--;
      end else if ($urandom_range(0, 49) == 0) begin
        send_quiet = $urandom_range(20, 60);
      end else if ($urandom_range(0, 5) == 0) begin
        in_valid_i <= 1'b0;
        repeat ($urandom_range(1, 4)) @(posedge clk_i);
      end
    end
    in_valid_i    <= 1'b1;
    data_symbol_i <= d;
    last_symbol_i <= l;
    @(posedge clk_i);
    while (in_stall_o !== 1'b0) begin
      @(posedge clk_i);
    end
    items_sent++;
  endtask

  task automatic wait_drained();
    in_valid_i <= 1'b0;
    while (parity_q.size() != 0) begin
      @(posedge clk_i);
    end
  endtask

  initial begin : main
    stim_row_t        dir_tab [20];
    logic [SymBits:0] fv;
    blk_kind_e        kind;
    int               len;
    logic [7:0]       d;
    logic             l;

    fv = 1;
    for (int i = 0; i < FieldSize; i++) begin
      alog[i]             = fv[SymBits-1:0];
      alog[i + FieldSize] = fv[SymBits-1:0];
      glog[fv[SymBits-1:0]] = i;
      fv = fv << 1;
      if (fv[SymBits]) begin
        fv = fv ^ FieldPoly;
      end
    end
    for (int k = 0; k <= ParLen; k++) begin
      gen_tap[k] = '0;
    end
    gen_tap[0] = sym_t'(1);
    for (int i = 1; i <= ParLen; i++) begin
      for (int j = i; j >= 1; j--) begin
        gen_tap[j] = gen_tap[j-1] ^ gf_times(gen_tap[j], alog[i]);
      end
      gen_tap[0] = gf_times(gen_tap[0], alog[i]);
    end
    for (int j = 0; j < ParLen; j++) begin
      lfsr_rem[j] = '0;
    end
    blk_len = 0;
    blk_ovf = 1'b0;

    // data, last, typed, expected symbol / eop / err, hold-off
    dir_tab = '{
      '{8'h00, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},  // one-symbol blocks at the extremes
      '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'h55, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},  // no last mark: nothing comes out
      '{8'hAA, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'h01, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
      '{8'h80, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
      '{8'h7F, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'h3C, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b1},  // receiver holds off, errors pile up
      '{8'hC3, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'h0F, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'hF0, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'h11, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'hEE, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'h22, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'hDD, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'h44, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'hBB, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0},
      '{8'hFE, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
      '{8'h00, 1'b0, 1'b1, 8'h00, 1'b0, 1'b0, 1'b0},
      '{8'hFF, 1'b1, 1'b1, 8'h00, 1'b1, 1'b1, 1'b0}
    };

    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_tab[r]) begin
      if (dir_tab[r].hold) begin
        hold_req = 1'b1;
      end
      send_symbol(dir_tab[r].data, dir_tab[r].last);
      predict_symbol(dir_tab[r].data, dir_tab[r].last, !dir_tab[r].typed);
      if (dir_tab[r].typed && dir_tab[r].last) begin
        parity_q.push_back('{dir_tab[r].exp_sym, dir_tab[r].exp_eop, dir_tab[r].exp_err});
        parity_pushed++;
      end
    end
    wait_drained();

    // a full codeword, then short blocks, under random stalls on both sides
    for (int b = 0; b < 3 || items_sent < ItemsTarget - LongLen; b++) begin
      kind = (b == 0) ? BlkGood : BlkShort;
      if (kind == BlkGood) begin
        len = DataLen;
      end else begin
        len = $urandom_range(1, 20);
      end
      for (int k = 1; k <= len; k++) begin
        d = 8'($urandom_range(0, 255));
        l = (k == len);
        send_symbol(d, l);
        predict_symbol(d, l, 1'b1);
      end
    end

    // overlong block at full rate on both sides: the count saturates
    wait_drained();
    calm = 1'b1;
    for (int k = 1; k <= LongLen; k++) begin
      d = 8'($urandom_range(0, 255));
      l = (k == LongLen);
      send_symbol(d, l);
      predict_symbol(d, l, 1'b1);
    end
    wait_drained();
    repeat (TailCycles) @(posedge clk_i);

    $display("run: %0d symbols, %0d full codewords, %0d length errors (%0d overlong)",
             items_sent, n_full, n_err, n_ovf);
    $display("run: %0d results checked, input held back for %0d cycles",
             results_seen, in_stall_seen);
    if (fail_cnt == 0) begin
      $display("** reed_solomon_parity_encoder: PASSED **");
    end else begin
      $display("** reed_solomon_parity_encoder: FAILED **");
    end
    $finish;
  end

endmodule
